// ===== hw/rtl/bsa_pkg.sv =====
// Shared types and constants for the bitmap slab allocator.
// No dependencies; imported by bsa_word_scan, the core and the testbench.
package bsa_pkg;

  localparam int unsigned HDR_BYTES   = 32;
  localparam int unsigned MIN_CLASS   = 8;
  localparam int unsigned NUM_CLASSES = 9;  // 8 .. 2048 bytes
  localparam int unsigned WORD_BITS   = 64;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_CHUNK = 2'd1;
  localparam logic [1:0] ST_BAD_SIZE = 2'd2;
  localparam logic [1:0] ST_BAD_FREE = 2'd3;

  // per-chunk metadata word
  typedef struct packed {
    logic [31:0] order;
    logic [3:0]  cls;
  } meta_t;

  // word scanner result
  typedef struct packed {
    logic       found;
    logic [5:0] pos;
  } scan_t;

endpackage

// ===== hw/rtl/bsa_ram.sv =====
// Simple dual-port RAM, one write and one registered read per cycle.
// Used for slot bitmaps and chunk metadata; no package dependencies.
module bsa_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/bsa_word_scan.sv =====
// Finds the lowest clear bit of one bitmap word that lies below the capacity.
// Depends on bsa_pkg (scan_t).
module bsa_word_scan #(
  parameter int unsigned WB    = 3,
  parameter int unsigned CAP_W = 9
) (
  input  logic [63:0]      word,
  input  logic [WB-1:0]    widx,
  input  logic [CAP_W-1:0] cap,
  output bsa_pkg::scan_t   res
);
  import bsa_pkg::*;

  localparam int unsigned AW = WB + 7;

  logic [AW-1:0] left;
  logic [63:0]   lim;
  logic [63:0]   avail;

  always_comb begin
    left = AW'(cap) - AW'({widx, 6'b0});
    if (left >= AW'(WORD_BITS)) begin
      lim = '1;
    end else begin
      lim = (64'd1 << left[5:0]) - 64'd1;
    end
    avail = ~word & lim;
    res = '0;
    for (int b = WORD_BITS - 1; b >= 0; b--) begin
      if (avail[b]) begin
        res.found = 1'b1;
        res.pos   = 6'(b);
      end
    end
  end

endmodule

// ===== hw/rtl/bitmap_slab_allocator_core.sv =====
// Bitmap slab allocator core: sequencer, bitmap and metadata RAMs.
// Depends on bsa_pkg, bsa_ram and bsa_word_scan.
//
// One request at a time. An allocate looks up the class, then visits each
// chunk slot: one not live is only checked, a live one has its metadata
// read and, if of the same class, its bitmap words until one holds a free
// slot. Else a new chunk is taken, with a clearing sweep of its bitmap words;
// then the slot bit is set and the address formed. A bad size ends after
// the class lookup. A free finds its chunk by repeated subtraction of
// CHUNK_BYTES, reads its metadata, checks and clears the slot bit and scans
// the bitmap for emptiness; null and bad frees end early. The bitmap RAM's
// single read port (one word per cycle) paces the scans. A finished result
// sits in an output register; the block waits while an older result is
// still unaccepted and is ready again the cycle after it registers one.
module bitmap_slab_allocator_core #(
  parameter int unsigned CHUNK_BYTES    = 4096,
  parameter int unsigned NUM_CHUNKS     = 16,
  parameter int unsigned MAX_SLAB_BYTES = 2048
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // req_size[15:0], free_addr[31:16]
  input  logic        s_axis_tuser,   // op
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata    // alloc_addr[15:0], status[17:16],
                                      // chunk_released[18], zero[23:19]
);
  import bsa_pkg::*;

  localparam int unsigned MAP_BITS  = 8 * CHUNK_BYTES - 8 * HDR_BYTES - 7;
  localparam int unsigned CAP_TAB [NUM_CLASSES] = '{
    MAP_BITS / 65, MAP_BITS / 129, MAP_BITS / 257, MAP_BITS / 513,
    MAP_BITS / 1025, MAP_BITS / 2049, MAP_BITS / 4097, MAP_BITS / 8193,
    MAP_BITS / 16385};
  localparam int unsigned MAP_WORDS = (CAP_TAB[0] + 63) / 64;
  localparam int unsigned WB        = $clog2(MAP_WORDS);
  localparam int unsigned BIT_W     = WB + 6;
  localparam int unsigned CAP_W     = $clog2(CAP_TAB[0] + 1);
  localparam int unsigned CI_W      = $clog2(NUM_CHUNKS);
  localparam int unsigned BM_DEPTH  = NUM_CHUNKS << WB;
  localparam int unsigned BM_AW     = CI_W + WB;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CLS   = 4'd1;
  localparam logic [3:0] S_CHK   = 4'd2;
  localparam logic [3:0] S_META  = 4'd3;
  localparam logic [3:0] S_WORD  = 4'd4;
  localparam logic [3:0] S_PICK  = 4'd5;
  localparam logic [3:0] S_TAKE  = 4'd6;
  localparam logic [3:0] S_SET   = 4'd7;
  localparam logic [3:0] S_MUL   = 4'd8;
  localparam logic [3:0] S_ADDR  = 4'd9;
  localparam logic [3:0] S_FDIV  = 4'd10;
  localparam logic [3:0] S_FMETA = 4'd11;
  localparam logic [3:0] S_FBIT  = 4'd12;
  localparam logic [3:0] S_FEMP  = 4'd13;
  localparam logic [3:0] S_FEMPL = 4'd14;
  localparam logic [3:0] S_DONE  = 4'd15;

  localparam logic [CI_W-1:0] LAST_C = CI_W'(NUM_CHUNKS - 1);
  localparam logic [WB-1:0]   LAST_W = WB'(MAP_WORDS - 1);
  localparam logic [16:0]     CB_V   = 17'(CHUNK_BYTES);

  logic [3:0]            state;
  logic [15:0]           req_r;
  logic [15:0]           faddr_r;
  logic [3:0]            ci;
  logic [CAP_W-1:0]      cap;
  logic [CAP_W-1:0]      mapb;
  logic [CI_W-1:0]       c;
  logic [WB-1:0]         w;
  logic                  best_vld;
  logic [CI_W-1:0]       best_c;
  logic [BIT_W-1:0]      best_bit;
  logic [31:0]           best_age;
  logic [63:0]           best_word;
  logic [16:0]           rem;
  logic [BIT_W-1:0]      idx;
  logic                  nz;
  logic                  chk_v;
  logic [31:0]           base;
  logic [31:0]           order_counter;
  logic [NUM_CHUNKS-1:0] live;
  logic [15:0]           res_addr;
  logic [1:0]            res_status;
  logic                  res_rel;

  // RAM ports
  logic             bm_we;
  logic [BM_AW-1:0] bm_waddr;
  logic [63:0]      bm_wdata;
  logic [BM_AW-1:0] bm_raddr;
  logic [63:0]      bm_rd;
  logic             mt_we;
  meta_t            mt_wdata;
  meta_t            mt_rd;

  // class lookup and derived values
  logic [3:0]       ci_calc;
  logic [3:0]       lu_ci;
  logic [CAP_W-1:0] cap_lu;
  logic [CAP_W-1:0] mapb_lu;
  logic [16:0]      dstart;
  logic [16:0]      idx_full;
  logic [31:0]      age;
  logic [CI_W-1:0]  free_slot;
  scan_t            scan;

  bsa_ram #(.WIDTH(64), .DEPTH(BM_DEPTH)) u_bitmap (
    .clk(clk), .we(bm_we), .waddr(bm_waddr), .wdata(bm_wdata),
    .raddr(bm_raddr), .rdata(bm_rd)
  );

  bsa_ram #(.WIDTH($bits(meta_t)), .DEPTH(NUM_CHUNKS)) u_meta (
    .clk(clk), .we(mt_we), .waddr(c), .wdata(mt_wdata),
    .raddr(c), .rdata(mt_rd)
  );

  bsa_word_scan #(.WB(WB), .CAP_W(CAP_W)) u_scan (
    .word(bm_rd), .widx(w), .cap(cap), .res(scan)
  );

  always_comb begin
    ci_calc = '0;
    for (int k = NUM_CLASSES - 1; k >= 0; k--) begin
      if (17'(req_r) <= (17'(MIN_CLASS) << k)) begin
        ci_calc = 4'(k);
      end
    end
    lu_ci   = (state == S_CLS) ? ci_calc : mt_rd.cls;
    cap_lu  = (lu_ci < 4'(NUM_CLASSES)) ? CAP_W'(CAP_TAB[lu_ci]) : '0;
    mapb_lu = CAP_W'((CAP_W + 1)'(cap_lu) + (CAP_W + 1)'(7) >> 3);
    dstart  = 17'(HDR_BYTES) + 17'(mapb_lu);
    idx_full = (rem - dstart) >> (5'(mt_rd.cls) + 5'd3);
    age     = order_counter - mt_rd.order;
    free_slot = '0;
    for (int k = NUM_CHUNKS - 1; k >= 0; k--) begin
      if (!live[k]) begin
        free_slot = CI_W'(k);
      end
    end
  end

  // RAM control
  always_comb begin
    bm_we    = 1'b0;
    bm_waddr = {best_c, best_bit[BIT_W-1:6]};
    bm_wdata = best_word | (64'd1 << best_bit[5:0]);
    bm_raddr = {c, w};
    mt_we    = 1'b0;
    mt_wdata = '{order: order_counter, cls: ci};
    unique case (state)
      S_META:  bm_raddr = {c, {WB{1'b0}}};
      S_WORD:  bm_raddr = {c, w + WB'(1)};
      S_FMETA: bm_raddr = {c, idx_full[BIT_W-1:6]};
      S_TAKE: begin
        // new chunk metadata goes in with the first clearing write
        mt_we    = (w == '0);
        bm_we    = 1'b1;
        bm_waddr = {c, w};
        bm_wdata = '0;
      end
      S_SET:   bm_we = 1'b1;
      S_FBIT: begin
        bm_we    = bm_rd[idx[5:0]];
        bm_waddr = {c, idx[BIT_W-1:6]};
        bm_wdata = bm_rd & ~(64'd1 << idx[5:0]);
      end
      default: ;
    endcase
  end

  assign s_axis_tready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      live          <= '0;
      order_counter <= '0;
      m_axis_tvalid <= 1'b0;
      chk_v         <= 1'b0;
    end else begin
      chk_v <= (state == S_FEMP);
      if (m_axis_tvalid && m_axis_tready && state != S_DONE) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            req_r      <= s_axis_tdata[15:0];
            faddr_r    <= s_axis_tdata[31:16];
            rem        <= {1'b0, s_axis_tdata[31:16]};
            c          <= '0;
            res_addr   <= '0;
            res_status <= ST_OK;
            res_rel    <= 1'b0;
            best_vld   <= 1'b0;
            state      <= (s_axis_tuser == OP_FREE) ? S_FDIV : S_CLS;
          end
        end
        S_CLS: begin
          if (32'(req_r) >= MAX_SLAB_BYTES || cap_lu == '0) begin
            res_status <= ST_BAD_SIZE;
            state      <= S_DONE;
          end else begin
            ci    <= ci_calc;
            cap   <= cap_lu;
            mapb  <= mapb_lu;
            state <= S_CHK;
          end
        end
        S_CHK: begin
          if (live[c]) begin
            state <= S_META;
          end else if (c == LAST_C) begin
            state <= S_PICK;
          end else begin
            c <= c + CI_W'(1);
          end
        end
        S_META: begin
          w <= '0;
          if (mt_rd.cls == ci) begin
            state <= S_WORD;
          end else if (c == LAST_C) begin
            state <= S_PICK;
          end else begin
            c     <= c + CI_W'(1);
            state <= S_CHK;
          end
        end
        S_WORD: begin
          if (scan.found) begin
            if (!best_vld || age > best_age) begin
              best_vld  <= 1'b1;
              best_c    <= c;
              best_bit  <= {w, scan.pos};
              best_age  <= age;
              best_word <= bm_rd;
            end
          end
          if (!scan.found && w != LAST_W &&
              (BIT_W + 1)'({w + WB'(1), 6'b0}) < (BIT_W + 1)'(cap)) begin
            w <= w + WB'(1);
          end else if (c == LAST_C) begin
            state <= S_PICK;
          end else begin
            c     <= c + CI_W'(1);
            state <= S_CHK;
          end
        end
        S_PICK: begin
          if (best_vld) begin
            state <= S_SET;
          end else if (&live) begin
            res_status <= ST_NO_CHUNK;
            state      <= S_DONE;
          end else begin
            // new chunk in the lowest free slot
            c         <= free_slot;
            best_c    <= free_slot;
            best_bit  <= '0;
            best_word <= '0;
            w         <= '0;
            state     <= S_TAKE;
          end
        end
        S_TAKE: begin
          if (w == '0) begin
            live[c]       <= 1'b1;
            order_counter <= order_counter + 32'd1;
          end
          if (w == LAST_W) begin
            state <= S_SET;
          end else begin
            w <= w + WB'(1);
          end
        end
        S_SET: begin
          state <= S_MUL;
        end
        S_MUL: begin
          base  <= 32'(best_c) * 32'(CHUNK_BYTES);
          state <= S_ADDR;
        end
        S_ADDR: begin
          res_addr <= 16'(base + 32'(HDR_BYTES) + 32'(mapb) +
                          (32'(best_bit) << (5'(ci) + 5'd3)));
          state    <= S_DONE;
        end
        S_FDIV: begin
          if (faddr_r == '0) begin
            state <= S_DONE;
          end else if (rem >= CB_V) begin
            if (c == LAST_C) begin
              res_status <= ST_BAD_FREE;
              state      <= S_DONE;
            end else begin
              rem <= rem - CB_V;
              c   <= c + CI_W'(1);
            end
          end else if (!live[c]) begin
            res_status <= ST_BAD_FREE;
            state      <= S_DONE;
          end else begin
            state <= S_FMETA;
          end
        end
        S_FMETA: begin
          if (rem < dstart || idx_full >= 17'(cap_lu)) begin
            res_status <= ST_BAD_FREE;
            state      <= S_DONE;
          end else begin
            idx   <= idx_full[BIT_W-1:0];
            state <= S_FBIT;
          end
        end
        S_FBIT: begin
          if (!bm_rd[idx[5:0]]) begin
            res_status <= ST_BAD_FREE;
            state      <= S_DONE;
          end else begin
            w     <= '0;
            nz    <= 1'b0;
            state <= S_FEMP;
          end
        end
        S_FEMP: begin
          if (chk_v && bm_rd != '0) begin
            nz <= 1'b1;
          end
          if (w == LAST_W) begin
            state <= S_FEMPL;
          end else begin
            w <= w + WB'(1);
          end
        end
        S_FEMPL: begin
          if (!nz && bm_rd == '0) begin
            live[c] <= 1'b0;
            res_rel <= 1'b1;
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= {5'b0, res_rel, res_status, res_addr};
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("request accepted while busy");

  a_release_ok: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tdata[18]) |->
      (m_axis_tdata[17:16] == ST_OK && m_axis_tdata[15:0] == 16'd0))
    else $error("chunk release with error or address");

  a_err_no_addr: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tdata[17:16] != ST_OK) |-> m_axis_tdata[15:0] == 16'd0)
    else $error("error result carries an address");

  a_take_counts: assert property (@(posedge clk) disable iff (rst)
    (state == S_TAKE && w == '0) |=>
      $countones(live) == $countones($past(live)) + 1)
    else $error("chunk take did not add one live chunk");

endmodule

// ===== sim/tb_bitmap_slab_allocator_core.sv =====
// Self-checking testbench for bitmap_slab_allocator_core: directed and random
// allocate/free requests checked against an in-bench allocator model.
// Depends on bsa_pkg and the core RTL.
module tb_bitmap_slab_allocator_core;
  import bsa_pkg::*;

  localparam int unsigned CHUNK_BYTES    = 4096;
  localparam int unsigned NUM_CHUNKS     = 16;
  localparam int unsigned MAX_SLAB_BYTES = 2048;
  localparam int unsigned DATA_BITS      = 8 * CHUNK_BYTES - 8 * HDR_BYTES - 7;
  localparam int unsigned MAP_WORDS      = (DATA_BITS / (1 + 8 * MIN_CLASS) + 63) / 64;
  localparam int unsigned MAP_BITS       = MAP_WORDS * WORD_BITS;
  localparam int unsigned IDLE_LIMIT     = 5000;

  typedef struct {
    logic [15:0] addr;
    logic [1:0]  status;
    logic        released;
  } grant_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic        s_axis_tuser = OP_ALLOC;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;

  bitmap_slab_allocator_core #(
    .CHUNK_BYTES(CHUNK_BYTES), .NUM_CHUNKS(NUM_CHUNKS), .MAX_SLAB_BYTES(MAX_SLAB_BYTES)
  ) i_dut (.*);

  initial forever #5 clk = ~clk;

  // allocator model state
  logic                chunk_live [NUM_CHUNKS];
  logic [3:0]          chunk_cls  [NUM_CHUNKS];
  logic [31:0]         chunk_age0 [NUM_CHUNKS];
  logic [31:0]         take_count;
  logic [MAP_BITS-1:0] chunk_map  [NUM_CHUNKS];

  grant_t grant_q[$];
  logic [15:0] held_addrs[$];
  int errors = 0;
  int idle_pct = 0, stall_pct = 0;
  bit hold_off = 0;
  int n_alloc = 0, n_free = 0, n_release = 0, n_exhaust = 0, n_bad = 0;
  int idle_cycles = 0;

  function automatic int unsigned slots_per_chunk(int unsigned cls);
    return DATA_BITS / (1 + 8 * cls);
  endfunction

  function automatic int unsigned data_start(int unsigned cls);
    return HDR_BYTES + (slots_per_chunk(cls) + 7) / 8;
  endfunction

  // apply one request to the model and return the expected response
  function automatic grant_t predict_grant(logic op, logic [15:0] size, logic [15:0] addr);
    grant_t g;
    int unsigned cls, ci, cap, c, off, idx, age, best_age;
    int best_c, best_bit, bit_i;
    g = '{addr: '0, status: ST_OK, released: 1'b0};
    if (op == OP_ALLOC) begin
      if (size >= MAX_SLAB_BYTES) begin
        g.status = ST_BAD_SIZE;
        return g;
      end
      cls = MIN_CLASS;
      ci = 0;
      while (cls < size) begin
        cls = cls << 1;
        ci++;
      end
      cap = slots_per_chunk(cls);
      if (cap == 0 || ci > 15) begin
        g.status = ST_BAD_SIZE;
        return g;
      end
      best_c = -1;
      best_bit = -1;
      best_age = 0;
      for (c = 0; c < NUM_CHUNKS; c++) begin
        if (!chunk_live[c] || chunk_cls[c] != ci[3:0]) continue;
        bit_i = -1;
        for (int i = 0; i < cap && i < MAP_BITS; i++)
          if (!chunk_map[c][i]) begin
            bit_i = i;
            break;
          end
        if (bit_i < 0) continue;
        age = take_count - chunk_age0[c];
        if (best_c < 0 || age > best_age) begin
          best_c = c;
          best_bit = bit_i;
          best_age = age;
        end
      end
      if (best_c < 0) begin
        for (c = 0; c < NUM_CHUNKS; c++)
          if (!chunk_live[c]) break;
        if (c >= NUM_CHUNKS) begin
          g.status = ST_NO_CHUNK;
          return g;
        end
        chunk_live[c] = 1'b1;
        chunk_cls[c] = ci[3:0];
        chunk_age0[c] = take_count;
        take_count++;
        chunk_map[c] = '0;
        best_c = c;
        best_bit = 0;
      end
      chunk_map[best_c][best_bit] = 1'b1;
      g.addr = 16'(best_c * CHUNK_BYTES + data_start(cls) + best_bit * cls);
      return g;
    end
    if (addr == 0) return g;
    c = addr / CHUNK_BYTES;
    if (c >= NUM_CHUNKS || !chunk_live[c]) begin
      g.status = ST_BAD_FREE;
      return g;
    end
    cls = MIN_CLASS << chunk_cls[c];
    cap = slots_per_chunk(cls);
    off = addr - c * CHUNK_BYTES;
    if (off < data_start(cls)) begin
      g.status = ST_BAD_FREE;
      return g;
    end
    idx = (off - data_start(cls)) / cls;  // misaligned address truncates to its slot
    if (idx >= cap || idx >= MAP_BITS || !chunk_map[c][idx]) begin
      g.status = ST_BAD_FREE;
      return g;
    end
    chunk_map[c][idx] = 1'b0;
    if (chunk_map[c] == '0) begin
      chunk_live[c] = 1'b0;
      g.released = 1'b1;
    end
    return g;
  endfunction

  // one request; returns the predicted response. Called at a falling edge.
  task automatic send_request(input logic op, input logic [15:0] size,
                              input logic [15:0] addr, output grant_t g);
    if ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid = 1'b0;
      repeat ($urandom_range(1, 20)) @(negedge clk);
    end
    s_axis_tuser = op;
    s_axis_tdata = {addr, size};
    s_axis_tvalid = 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    g = predict_grant(op, size, addr);
    grant_q.push_back(g);
    if (op == OP_ALLOC) begin
      n_alloc++;
      if (g.status == ST_OK) held_addrs.push_back(g.addr);
      if (g.status == ST_NO_CHUNK) n_exhaust++;
    end else begin
      n_free++;
      if (g.released) n_release++;
      if (g.status == ST_BAD_FREE) n_bad++;
    end
    @(negedge clk);
  endtask

  task automatic do_alloc(input logic [15:0] size, output grant_t g);
    send_request(OP_ALLOC, size, 16'($urandom), g);
  endtask

  task automatic do_free(input logic [15:0] addr);
    grant_t g;
    send_request(OP_FREE, 16'($urandom), addr, g);
  endtask

  task automatic free_held(input int i, input int offs);
    logic [15:0] a;
    a = held_addrs[i];
    held_addrs.delete(i);
    do_free(16'(a + offs));
  endtask

  task automatic test_size_classes();
    grant_t g;
    logic [15:0] sizes[12] = '{16'd0, 16'd1, 16'd8, 16'd9, 16'd16, 16'd1024, 16'd1025,
                               16'd2047, 16'd2048, 16'hFFFF, 16'd64, 16'd65};
    foreach (sizes[i]) do_alloc(sizes[i], g);
  endtask

  task automatic test_free_cases();
    grant_t a0, a1;
    logic [15:0] base;
    do_alloc(16'd3, a0);
    do_alloc(16'd5, a1);
    base = a0.addr & 16'hF000;
    do_free(16'(a1.addr + 3));              // misaligned frees its slot
    do_free(a1.addr);                       // already clear
    do_free(16'(base + 4));                 // inside the header
    do_free(base + 16'(CHUNK_BYTES - 1));   // slot index past capacity
    do_free(16'hF010);                      // chunk not live
    do_free(16'h0000);                      // null
    while (held_addrs.size() > 0) free_held(0, 0);
  endtask

  task automatic test_pool_exhaust();
    grant_t g;
    for (int i = 0; i <= NUM_CHUNKS; i++) do_alloc(16'd2000, g);
    do_alloc(16'd1500, g);
    while (held_addrs.size() > 0) free_held(held_addrs.size() - 1, 0);
  endtask

  // receiver holds off in its own process while requests keep coming
  task automatic test_backpressure();
    grant_t g;
    fork
      begin
        hold_off = 1;
        repeat (400) @(posedge clk);
        @(negedge clk);
        hold_off = 0;
      end
    join_none
    for (int i = 0; i < 12; i++) do_alloc(16'($urandom_range(0, 200)), g);
  endtask

  function automatic logic [15:0] random_size();
    int k;
    k = $urandom_range(99);
    if (k < 45) return 16'($urandom_range(0, 64));
    if (k < 75) return 16'($urandom_range(0, MAX_SLAB_BYTES - 1));
    if (k < 92) return 16'((16'd1 << $urandom_range(0, 11)) + $urandom_range(0, 1));
    return 16'($urandom);
  endfunction

  task automatic test_random(input int n, input int ip, input int sp);
    grant_t g;
    int k;
    idle_pct = ip;
    stall_pct = sp;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(99);
      if (held_addrs.size() > 120) k = k + 30;
      if (k < 8) do_free(16'($urandom));
      else if (k < 55 || held_addrs.size() == 0) do_alloc(random_size(), g);
      else if (k < 60) do_free(held_addrs[$urandom_range(0, held_addrs.size() - 1)]);
      else free_held($urandom_range(0, held_addrs.size() - 1), $urandom_range(0, 7));
    end
    idle_pct = 0;
    stall_pct = 0;
  endtask

  // receiver
  always @(negedge clk)
    m_axis_tready <= !hold_off && ($urandom_range(99) >= stall_pct);

  // response checker
  always @(posedge clk) begin
    grant_t e;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (grant_q.size() == 0) begin
        $error("unexpected response %h", m_axis_tdata);
        errors++;
      end else begin
        e = grant_q.pop_front();
        if (m_axis_tdata[15:0] !== e.addr) begin
          $error("alloc_addr exp %h got %h", e.addr, m_axis_tdata[15:0]);
          errors++;
        end
        if (m_axis_tdata[17:16] !== e.status) begin
          $error("status exp %0d got %0d", e.status, m_axis_tdata[17:16]);
          errors++;
        end
        if (m_axis_tdata[18] !== e.released) begin
          $error("chunk_released exp %0d got %0d", e.released, m_axis_tdata[18]);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles with no handshake
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || rst)
      idle_cycles <= 0;
    else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    for (int c = 0; c < NUM_CHUNKS; c++) begin
      chunk_live[c] = 1'b0;
      chunk_map[c] = '0;
    end
    take_count = '0;
    repeat (10) @(negedge clk);
    rst = 1'b0;
    test_size_classes();
    test_free_cases();
    test_pool_exhaust();
    test_backpressure();
    test_random(320, 0, 0);
    test_random(300, 78, 0);
    test_random(300, 0, 78);
    test_random(300, 11, 11);
    s_axis_tvalid = 1'b0;
    wait (grant_q.size() == 0);
    repeat (200) @(negedge clk);
    $display("Covered %0d allocates (%0d pool exhausted) and %0d frees", n_alloc, n_exhaust,
             n_free);
    $display("with %0d chunk releases and %0d rejected frees", n_release, n_bad);
    if (errors == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
